// ===== rtl/core/call_latency_stats_table_macros.svh =====
// assertion macros used by the call latency stats table controller
// no dependencies
`ifndef CALL_LATENCY_STATS_TABLE_MACROS_SVH
`define CALL_LATENCY_STATS_TABLE_MACROS_SVH

// implication checked every cycle outside reset
`define CLST_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication checked outside reset
`define CLST_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/clst_pkg.sv =====
// shared types and constants for the call latency stats table
// no dependencies
package clst_pkg;

    localparam logic [2:0] ST_BEGIN_STORED = 3'd0;
    localparam logic [2:0] ST_BEGIN_FULL   = 3'd1;
    localparam logic [2:0] ST_NO_BEGIN     = 3'd2;
    localparam logic [2:0] ST_UPDATED      = 3'd3;
    localparam logic [2:0] ST_CREATED      = 3'd4;
    localparam logic [2:0] ST_STATS_FULL   = 3'd5;

    localparam int BKEY_W = 50;
    localparam int SKEY_W = 42;

    // controller to datapath
    typedef struct packed {
        logic load;        // capture input item
        logic bscan_step;  // examine one begin entry
        logic sscan_step;  // examine one stats entry
        logic scan_clr;    // restart scan pointer
        logic brd;         // read begin time at hit
        logic srd;         // read stats entry at hit
        logic bwr;         // write begin entry
        logic swr;         // write stats entry
        logic res_load;    // latch result
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic scan_last;
        logic bhit;
        logic bfree;
        logic shit;
        logic sfree;
        logic is_end;
    } t_sts;

endpackage

// ===== rtl/core/clst_ram.sv =====
// generic single-port-write, one-read ram with registered read
// no dependencies
module clst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/core/clst_datapath.sv =====
// datapath: key rams, scan pointer, valid bits, duration and statistics math
// depends on clst_pkg and clst_ram
module clst_datapath #(
    parameter int BEGIN_ENTRIES = 64,
    parameter int STATS_ENTRIES = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  clst_pkg::t_cmd      i_cmd,
    output clst_pkg::t_sts      o_sts,
    input  logic [114:0]        i_item,
    output logic [322:0]        o_result
);
    localparam int BA_W = (BEGIN_ENTRIES > 1) ? $clog2(BEGIN_ENTRIES) : 1;
    localparam int SA_W = (STATS_ENTRIES > 1) ? $clog2(STATS_ENTRIES) : 1;
    localparam int MAX_E = (BEGIN_ENTRIES > STATS_ENTRIES) ? BEGIN_ENTRIES : STATS_ENTRIES;
    localparam int P_W = $clog2(MAX_E + 1);
    localparam int BRAM_D = (BEGIN_ENTRIES > 1) ? BEGIN_ENTRIES : 2;
    localparam int SRAM_D = (STATS_ENTRIES > 1) ? STATS_ENTRIES : 2;

    // captured item
    logic        r_type;
    logic [31:0] r_pid;
    logic [7:0]  r_cpu;
    logic [9:0]  r_evid;
    logic [63:0] r_now;

    logic [BEGIN_ENTRIES-1:0] r_bvalid, n_bvalid;
    logic [STATS_ENTRIES-1:0] r_svalid, n_svalid;
    logic [P_W-1:0] r_ptr;
    logic [P_W-1:0] r_ptr_d;   // address whose key is now on ram output
    logic           r_cmp_b, r_cmp_s;
    logic           r_bhit, r_bfree, r_shit, r_sfree;
    logic [BA_W-1:0] r_bhit_a, r_bfree_a;
    logic [SA_W-1:0] r_shit_a, r_sfree_a;
    logic [63:0]    r_dur;
    logic [322:0]   r_result;

    logic [clst_pkg::BKEY_W-1:0] bkey, bkey_q;
    logic [clst_pkg::SKEY_W-1:0] skey, skey_q;
    logic [63:0] btime_q, stot_q, scnt_q, smax_q, smin_q;
    logic [BA_W-1:0] b_raddr, b_waddr;
    logic [SA_W-1:0] s_raddr, s_waddr;
    logic [63:0] s_tot, s_cnt, s_max, s_min;
    logic [2:0]  st;

    assign bkey = {r_pid, r_cpu, r_evid};
    assign skey = {r_pid, r_evid};

    // ram reads follow the pointer, or the hit address while brd or srd is set
    assign b_raddr = i_cmd.brd ? r_bhit_a : r_ptr[BA_W-1:0];
    assign s_raddr = i_cmd.srd ? r_shit_a : r_ptr[SA_W-1:0];
    assign b_waddr = r_bhit ? r_bhit_a : r_bfree_a;
    assign s_waddr = r_shit ? r_shit_a : r_sfree_a;

    clst_ram #(.WIDTH(clst_pkg::BKEY_W), .DEPTH(BRAM_D)) u_bkey (
        .i_clk(i_clk), .i_we(i_cmd.bwr && !r_bhit), .i_waddr(b_waddr),
        .i_wdata(bkey), .i_raddr(b_raddr), .o_rdata(bkey_q));
    clst_ram #(.WIDTH(64), .DEPTH(BRAM_D)) u_btime (
        .i_clk(i_clk), .i_we(i_cmd.bwr), .i_waddr(b_waddr),
        .i_wdata(r_now), .i_raddr(b_raddr), .o_rdata(btime_q));
    clst_ram #(.WIDTH(clst_pkg::SKEY_W), .DEPTH(SRAM_D)) u_skey (
        .i_clk(i_clk), .i_we(i_cmd.swr && !r_shit), .i_waddr(s_waddr),
        .i_wdata(skey), .i_raddr(s_raddr), .o_rdata(skey_q));
    clst_ram #(.WIDTH(256), .DEPTH(SRAM_D)) u_sval (
        .i_clk(i_clk), .i_we(i_cmd.swr), .i_waddr(s_waddr),
        .i_wdata({s_tot, s_cnt, s_max, s_min}), .i_raddr(s_raddr),
        .o_rdata({stot_q, scnt_q, smax_q, smin_q}));

    // statistics update from the entry read at the hit address, or fresh stats without a hit
    always_comb begin
        if (r_shit) begin
            s_tot = stot_q + r_dur;
            s_cnt = scnt_q + 64'd1;
            s_max = (r_dur > smax_q) ? r_dur : smax_q;
            s_min = (r_dur < smin_q) ? r_dur : smin_q;
        end else begin
            s_tot = r_dur;
            s_cnt = 64'd1;
            s_max = r_dur;
            s_min = r_dur;
        end
    end

    always_comb begin
        n_bvalid = r_bvalid;
        n_svalid = r_svalid;
        if (i_cmd.bwr && !r_bhit) begin
            n_bvalid[r_bfree_a] = 1'b1;
        end
        if (i_cmd.swr && !r_shit) begin
            n_svalid[r_sfree_a] = 1'b1;
        end
    end

    always_comb begin
        if (!r_type) begin
            st = (r_bhit || r_bfree) ? clst_pkg::ST_BEGIN_STORED : clst_pkg::ST_BEGIN_FULL;
        end else if (!r_bhit) begin
            st = clst_pkg::ST_NO_BEGIN;
        end else if (r_shit) begin
            st = clst_pkg::ST_UPDATED;
        end else if (r_sfree) begin
            st = clst_pkg::ST_CREATED;
        end else begin
            st = clst_pkg::ST_STATS_FULL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bvalid <= '0;
            r_svalid <= '0;
            r_cmp_b  <= 1'b0;
            r_cmp_s  <= 1'b0;
        end else begin
            r_bvalid <= n_bvalid;
            r_svalid <= n_svalid;
            r_cmp_b  <= i_cmd.bscan_step;
            r_cmp_s  <= i_cmd.sscan_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            {r_now, r_evid, r_cpu, r_pid, r_type} <= i_item;
        end
        if (i_cmd.scan_clr) begin
            r_ptr <= '0;
        end else if (i_cmd.bscan_step || i_cmd.sscan_step) begin
            r_ptr <= r_ptr + 1'b1;
        end
        r_ptr_d <= r_ptr;
        if (i_cmd.load) begin
            r_bhit <= 1'b0; r_bfree <= 1'b0;
            r_shit <= 1'b0; r_sfree <= 1'b0;
        end else begin
            // compare key returned for the previous pointer, lowest index wins
            if (r_cmp_b) begin
                if (r_bvalid[r_ptr_d[BA_W-1:0]]) begin
                    if (!r_bhit && bkey_q == bkey) begin
                        r_bhit <= 1'b1; r_bhit_a <= r_ptr_d[BA_W-1:0];
                    end
                end else if (!r_bfree) begin
                    r_bfree <= 1'b1; r_bfree_a <= r_ptr_d[BA_W-1:0];
                end
            end
            if (r_cmp_s) begin
                if (r_svalid[r_ptr_d[SA_W-1:0]]) begin
                    if (!r_shit && skey_q == skey) begin
                        r_shit <= 1'b1; r_shit_a <= r_ptr_d[SA_W-1:0];
                    end
                end else if (!r_sfree) begin
                    r_sfree <= 1'b1; r_sfree_a <= r_ptr_d[SA_W-1:0];
                end
            end
        end
        if (i_cmd.srd) begin
            r_dur <= r_now - btime_q;
        end
        if (i_cmd.res_load) begin
            if (st == clst_pkg::ST_UPDATED || st == clst_pkg::ST_CREATED) begin
                r_result <= {s_min, s_max, s_cnt, s_tot, r_dur, st};
            end else if (st == clst_pkg::ST_STATS_FULL) begin
                r_result <= {256'd0, r_dur, st};
            end else begin
                r_result <= {320'd0, st};
            end
        end
    end

    assign o_sts.scan_last = i_cmd.sscan_step ? r_ptr == P_W'(STATS_ENTRIES - 1)
                                              : r_ptr == P_W'(BEGIN_ENTRIES - 1);
    assign o_sts.bhit   = r_bhit;
    assign o_sts.bfree  = r_bfree;
    assign o_sts.shit   = r_shit;
    assign o_sts.sfree  = r_sfree;
    assign o_sts.is_end = r_type;
    assign o_result = r_result;
endmodule

// ===== rtl/core/clst_ctrl.sv =====
// controller state machine sequencing table scans and entry updates
// depends on clst_pkg and call_latency_stats_table_macros.svh
`include "call_latency_stats_table_macros.svh"
module clst_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  clst_pkg::t_sts i_sts,
    output clst_pkg::t_cmd o_cmd
);
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_BSCAN  = 4'd1;
    localparam logic [3:0] S_BDRAIN = 4'd2;
    localparam logic [3:0] S_SSCAN  = 4'd3;
    localparam logic [3:0] S_SDRAIN = 4'd4;
    localparam logic [3:0] S_BRD    = 4'd5;
    localparam logic [3:0] S_DUR    = 4'd6;
    localparam logic [3:0] S_SRD    = 4'd7;
    localparam logic [3:0] S_RES    = 4'd8;
    localparam logic [3:0] S_OUT    = 4'd9;

    logic [3:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       take, res_free;

    assign res_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign take       = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd = '0;
        case (r_state)
            S_IDLE: begin
                if (take) begin
                    o_cmd.load = 1'b1;
                    o_cmd.scan_clr = 1'b1;
                    n_state = S_BSCAN;
                end
            end
            S_BSCAN: begin
                o_cmd.bscan_step = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_BDRAIN;
                end
            end
            S_BDRAIN: begin
                // last compare lands this cycle
                o_cmd.scan_clr = 1'b1;
                if (!i_sts.is_end) begin
                    n_state = S_RES;
                end else begin
                    n_state = S_BRD;
                end
            end
            S_BRD: begin
                o_cmd.brd = 1'b1;
                o_cmd.scan_clr = 1'b1;
                n_state = i_sts.bhit ? S_SSCAN : S_RES;
            end
            S_SSCAN: begin
                o_cmd.sscan_step = 1'b1;
                o_cmd.brd = 1'b0;
                if (i_sts.scan_last) begin
                    n_state = S_SDRAIN;
                end
            end
            S_SDRAIN: begin
                n_state = S_DUR;
            end
            S_DUR: begin
                // begin time at hit is read, capture duration while reading stats
                o_cmd.brd = 1'b1;
                n_state = S_SRD;
            end
            S_SRD: begin
                o_cmd.brd = 1'b1;
                o_cmd.srd = 1'b1;
                n_state = S_RES;
            end
            S_RES: begin
                // hold both read addresses so the duration survives a stall
                o_cmd.brd = 1'b1;
                o_cmd.srd = 1'b1;
                if (res_free) begin
                    o_cmd.res_load = 1'b1;
                    n_out_valid = 1'b1;
                    if (!i_sts.is_end) begin
                        o_cmd.bwr = i_sts.bhit || i_sts.bfree;
                    end else if (i_sts.bhit) begin
                        o_cmd.swr = i_sts.shit || i_sts.sfree;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    `CLST_ASSERT_IMP(a_one_write, i_clk, i_rst_n, 1'b1, !(o_cmd.bwr && o_cmd.swr), "two table writes")
    `CLST_ASSERT_NXT(a_take_scan, i_clk, i_rst_n, take, r_state == S_BSCAN, "no scan after take")
    `CLST_ASSERT_IMP(a_res_only, i_clk, i_rst_n, o_cmd.res_load, res_free, "result overwritten")
endmodule

// ===== rtl/core/call_latency_stats_table.sv =====
// call latency stats table: begin/end event pairing with per-key latency stats
// top level; depends on clst_pkg, clst_ctrl, clst_datapath, clst_ram
//
// usage:
//  s_axis carries one event item: tuser = req_type (0 begin, 1 end),
//  tdata = pid, cpu, event_id, now_ns. m_axis returns one result item per
//  event: tdata = status, duration_ns, total_ns, call_count, max_ns, min_ns.
//  begin events search the begin table by (pid, cpu, event_id) and store the
//  timestamp in the matching or lowest free slot; end events look up that
//  begin time, form the wrapping duration and fold it into the stats table
//  keyed by (pid, event_id).
//  timing: one item at a time, scanning each key ram one entry per cycle.
//  a begin item's result loads after the begin scan, an end item's after the
//  begin and stats scans (after the begin scan alone without a stored begin);
//  the next item is taken in the cycle after the result loads.
//  the result sits in an output register; the next input is taken as soon
//  as that result is loaded, so a stalled receiver holds only the following
//  item's final write until the register frees.
//  reset clears all valid bits at once, so both tables are empty with no
//  clearing pass; payload rams are left as they are.
module call_latency_stats_table #(
    parameter int BEGIN_ENTRIES = 64,
    parameter int STATS_ENTRIES = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [119:0] s_axis_tdata,  // pid, cpu, event_id, now_ns, zero pad
    input  logic         s_axis_tuser,  // req_type
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [327:0] m_axis_tdata   // status, duration_ns, total_ns,
                                         // call_count, max_ns, min_ns, zero pad
);
    clst_pkg::t_cmd cmd;
    clst_pkg::t_sts sts;
    logic [322:0]   result;

    clst_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .o_in_ready(s_axis_tready),
        .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_sts(sts), .o_cmd(cmd));

    clst_datapath #(.BEGIN_ENTRIES(BEGIN_ENTRIES), .STATS_ENTRIES(STATS_ENTRIES)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_sts(sts),
        .i_item({s_axis_tdata[113:0], s_axis_tuser}), .o_result(result));

    assign m_axis_tdata = {5'd0, result};
endmodule
